[hw/rtl/mcle_pkg.sv]
// ----------------------------------------------------------------------------
// mcle_pkg
// Types and constants shared by the control learn engine.
// ----------------------------------------------------------------------------
package mcle_pkg;

  localparam int MaxTargets = 64;
  localparam int ObsSlots   = 16;
  localparam int TgtW       = $clog2(MaxTargets);
  localparam int SlotW      = (ObsSlots > 1) ? $clog2(ObsSlots) : 1;
  localparam int QDepth     = 2;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_SKIP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CC       = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_e;

  localparam logic [1:0] REG_TARGET_COUNT = 2'd0;
  localparam logic [1:0] REG_MOMENTARY    = 2'd1;
  localparam logic [1:0] REG_REQ_MOVES    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  event_kind;
    logic [15:0] address_key;
    logic [6:0]  event_value;
  } in_item_t;

  typedef struct packed {
    logic        bound;
    logic [5:0]  bound_target;
    logic [15:0] bound_address;
    logic        session_active;
    logic        obs_overflow;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_begin;
    logic        is_skip;
    logic        is_event;
    logic        mom_ok;
    logic [15:0] key;
    logic [6:0]  value;
  } work_t;

  typedef struct packed {
    logic [6:0]  target_count;
    logic [63:0] momentary_mask;
    logic [3:0]  required_moves;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_BOUND,
    ST_SCAN_OBS,
    ST_UPDATE,
    ST_CLEAR,
    ST_OUT
  } state_e;

endpackage

[hw/rtl/mcle_front.sv]
// ----------------------------------------------------------------------------
// mcle_front
// Accepts items, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
module mcle_front import mcle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_ready,
  output work_t    q_item
);

  work_t            mem [QDepth];
  logic [0:0]       wp, rp;
  logic [1:0]       cnt;
  work_t            w;

  always_comb begin
    w.is_begin = (in_item.cmd == CMD_BEGIN);
    w.is_skip  = (in_item.cmd == CMD_SKIP);
    w.is_event = (in_item.cmd == CMD_EVENT) && (in_item.event_kind != KIND_NOTE_OFF);
    w.mom_ok   = (in_item.event_kind == KIND_NOTE_ON || in_item.event_kind == KIND_CC) &&
                 (in_item.event_value != 7'd0);
    w.key      = in_item.address_key;
    w.value    = in_item.event_value;
  end

  assign in_ready = (cnt != 2'(QDepth));
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= w;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 1'b1;
      if (q_valid && q_ready) rp <= rp + 1'b1;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

endmodule

[hw/rtl/mcle_back.sv]
// ----------------------------------------------------------------------------
// mcle_back
// Carries out one item: scans bound addresses and observation slots in turn.
// ----------------------------------------------------------------------------
module mcle_back import mcle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  work_t     q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_e state, state_next;

  logic [TgtW:0]   target_index, binding_count;
  logic [TgtW:0]   scan;
  logic [15:0]     bmem [MaxTargets];
  logic [15:0]     bread;
  logic            bread_ok;
  logic            in_use;

  logic [ObsSlots-1:0] obs_valid;
  logic [15:0]     obs_address [ObsSlots];
  logic [6:0]      obs_last [ObsSlots];
  logic [3:0]      obs_moves [ObsSlots];

  work_t           cur;
  logic            hit, have_free;
  logic [SlotW-1:0] hit_slot, free_slot;
  out_item_t       res;

  logic [TgtW:0]   eff_count;
  logic            active;
  logic            mom;
  logic [SlotW:0]  oscan;
  logic [SlotW-1:0] os;

  assign eff_count = (cfg.target_count > 7'(MaxTargets)) ? (TgtW+1)'(MaxTargets)
                                                        : (TgtW+1)'(cfg.target_count);
  assign active    = target_index < eff_count;
  assign mom       = cfg.momentary_mask[target_index[TgtW-1:0]];
  assign os        = oscan[SlotW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_SCAN_BOUND;
      ST_SCAN_BOUND: begin
        if (!(q_item.is_event && active)) state_next = ST_UPDATE;
        else if (bread_ok && bread == q_item.key) state_next = ST_UPDATE;
        else if (scan >= binding_count) state_next = ST_SCAN_OBS;
      end
      ST_SCAN_OBS: if (oscan == (SlotW+1)'(ObsSlots-1)) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_CLEAR;
      ST_CLEAR: state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == ST_OUT) && out_ready;
    out_valid = (state == ST_OUT);
    out_item  = res;
  end

  always_ff @(posedge clk) begin
    bread <= bmem[scan[TgtW-1:0]];
    if (state == ST_CLEAR && res.bound && binding_count < (TgtW+1)'(MaxTargets))
      bmem[binding_count[TgtW-1:0]] <= cur.key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      target_index <= '0;
      binding_count <= '0;
      obs_valid <= '0;
      bread_ok <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cur <= q_item;
          scan <= '0; oscan <= '0;
          bread_ok <= 1'b0; in_use <= 1'b0;
          hit <= 1'b0; have_free <= 1'b0;
          res <= '0;
        end
        ST_SCAN_BOUND: begin
          if (bread_ok && bread == q_item.key && scan <= binding_count) in_use <= 1'b1;
          bread_ok <= (scan < binding_count);
          scan <= scan + 1'b1;
        end
        ST_SCAN_OBS: begin
          if (obs_valid[os]) begin
            if (!hit && obs_address[os] == cur.key) begin
              hit <= 1'b1; hit_slot <= os;
            end
          end else if (!have_free) begin
            have_free <= 1'b1; free_slot <= os;
          end
          oscan <= oscan + 1'b1;
        end
        ST_UPDATE: begin
          if (cur.is_begin) begin
            target_index <= '0; binding_count <= '0; obs_valid <= '0;
          end else if (cur.is_skip) begin
            if (active) begin
              target_index <= target_index + 1'b1; obs_valid <= '0;
            end
          end else if (cur.is_event && active && !in_use) begin
            if (mom) begin
              if (cur.mom_ok) res.bound <= 1'b1;
            end else if (hit) begin
              if (obs_last[hit_slot] != cur.value) begin
                obs_last[hit_slot] <= cur.value;
                if (obs_moves[hit_slot] != 4'd15) obs_moves[hit_slot] <= obs_moves[hit_slot] + 1'b1;
                if (5'(obs_moves[hit_slot]) + 5'd1 >= 5'(cfg.required_moves)) res.bound <= 1'b1;
              end else if (obs_moves[hit_slot] >= cfg.required_moves) res.bound <= 1'b1;
            end else if (have_free) begin
              obs_valid[free_slot] <= 1'b1;
              obs_address[free_slot] <= cur.key;
              obs_last[free_slot] <= cur.value;
              obs_moves[free_slot] <= 4'd1;
              if (cfg.required_moves <= 4'd1) res.bound <= 1'b1;
            end else res.obs_overflow <= 1'b1;
          end
        end
        ST_CLEAR: begin
          if (res.bound) begin
            res.bound_target <= target_index[TgtW-1:0];
            res.bound_address <= cur.key;
            if (binding_count < (TgtW+1)'(MaxTargets)) binding_count <= binding_count + 1'b1;
            target_index <= target_index + 1'b1;
            obs_valid <= '0;
            res.session_active <= (target_index + 1'b1) < eff_count;
          end else res.session_active <= active;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/mcle_regs.sv]
// ----------------------------------------------------------------------------
// mcle_regs
// APB register file: target count, momentary mask, required moves.
// ----------------------------------------------------------------------------
module mcle_regs import mcle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0] idx;
  assign idx    = paddr[4:3];
  assign pready = 1'b1;

  always_comb begin
    unique case (idx)
      REG_TARGET_COUNT: prdata = {57'd0, cfg.target_count};
      REG_MOMENTARY:    prdata = cfg.momentary_mask;
      REG_REQ_MOVES:    prdata = {60'd0, cfg.required_moves};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_count <= '0;
      cfg.momentary_mask <= '0;
      cfg.required_moves <= 4'd3;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (idx)
        REG_TARGET_COUNT: cfg.target_count <= pwdata[6:0];
        REG_MOMENTARY:    cfg.momentary_mask <= pwdata;
        REG_REQ_MOVES:    cfg.required_moves <= pwdata[3:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/midi_control_learn_engine_unit.sv]
// ----------------------------------------------------------------------------
// midi_control_learn_engine_unit
// Each item passes through dispatch, a bound-address scan, a scan of the
// 16 observation slots, then update, finish and output states, one item
// at a time; commands and ignored events skip both scans, and a bound
// address skips the slot scan. The sequential scans in the back part limit
// throughput. Synchronous reset clears control state; the bound-address
// memory is undefined until written. A two-entry queue sits in front.
// ----------------------------------------------------------------------------
module midi_control_learn_engine_unit import mcle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  logic  q_valid, q_ready;
  work_t q_item;

  mcle_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .pready, .cfg);
  mcle_front u_front (.clk, .rst, .in_valid, .in_ready, .in_item,
                      .q_valid, .q_ready, .q_item);
  mcle_back u_back (.clk, .rst, .cfg, .q_valid, .q_ready, .q_item,
                    .out_valid, .out_ready, .out_item);

endmodule

[hw/rtl/mcle_checker.sv]
// ----------------------------------------------------------------------------
// mcle_checker
// Port-level checks for the learn engine.
// ----------------------------------------------------------------------------
module mcle_checker import mcle_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item,
  input logic      pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("out held");
  a_bound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.bound |-> out_item.bound_address == 16'd0 &&
    out_item.bound_target == 6'd0) else $error("unbound fields");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.bound && out_item.obs_overflow)) else $error("bound and overflow");
  a_pready: assert property (@(posedge clk) pready) else $error("pready");

endmodule

bind midi_control_learn_engine_unit mcle_checker u_chk (.clk, .rst, .out_valid,
  .out_ready, .out_item, .pready);
